### hdl/positional_list_store_unit_macros.svh
// Assertion macros shared by the list store RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef POSITIONAL_LIST_STORE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_STORE_UNIT_MACROS_SVH

// cons must hold in the same cycle as ante
`define PLS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pls_pkg.sv
package pls_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_DATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_FLD_W  = DATA_W + STAT_W + COUNT_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RETRIEVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOP,
    S_WR,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // take the input transaction
    logic check;     // latch status, load shift cursor
    logic rd_fetch;  // read entry at position
    logic rd_move;   // read neighbor of cursor
    logic wr_move;   // write neighbor data at cursor, step cursor
    logic put;       // write inserted value at position
    logic cnt_inc;
    logic cnt_dec;
    logic load_out;  // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              ok;        // request in range and not full
    logic              more;      // another entry still has to move
    logic              out_free;  // result register can take a new result
  } sts_t;

endpackage

### hdl/pls_ctrl.sv
module pls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  pls_pkg::sts_t sts,
  output pls_pkg::cmd_t cmd
);

  pls_pkg::state_t state_r;
  pls_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pls_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pls_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = pls_pkg::S_CHECK;
      end
      pls_pkg::S_CHECK: begin
        if (sts.ok && (sts.op inside {pls_pkg::FUNC_INSERT, pls_pkg::FUNC_DELETE})) begin
          state_nxt = pls_pkg::S_LOOP;
        end else begin
          state_nxt = pls_pkg::S_FINISH;
        end
      end
      pls_pkg::S_LOOP: begin
        state_nxt = sts.more ? pls_pkg::S_WR : pls_pkg::S_FINISH;
      end
      pls_pkg::S_WR: begin
        state_nxt = pls_pkg::S_LOOP;
      end
      pls_pkg::S_FINISH: begin
        if (sts.out_free) state_nxt = pls_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pls_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      pls_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      pls_pkg::S_CHECK: begin
        cmd.check    = 1'b1;
        cmd.rd_fetch = sts.ok && (sts.op == pls_pkg::FUNC_RETRIEVE);
      end
      pls_pkg::S_LOOP: begin
        if (sts.more) begin
          cmd.rd_move = 1'b1;
        end else if (sts.op == pls_pkg::FUNC_INSERT) begin
          cmd.put     = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      pls_pkg::S_WR: begin
        cmd.wr_move = 1'b1;
      end
      pls_pkg::S_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/pls_dp.sv
`include "positional_list_store_unit_macros.svh"

module pls_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pls_pkg::cmd_t               cmd,
  output pls_pkg::sts_t               sts,
  input  logic [pls_pkg::FUNC_W-1:0]  in_func,
  input  logic [pls_pkg::POS_W-1:0]   in_position,
  input  logic [pls_pkg::DATA_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pls_pkg::DATA_W-1:0]  out_read_value,
  output logic [pls_pkg::STAT_W-1:0]  out_status,
  output logic [pls_pkg::COUNT_W-1:0] out_count
);

  logic [pls_pkg::DATA_W-1:0]  store_r [pls_pkg::CAPACITY];
  logic [pls_pkg::DATA_W-1:0]  rd_data_r;

  logic [pls_pkg::FUNC_W-1:0]  op_r;
  logic [pls_pkg::POS_W-1:0]   pos_r;
  logic [pls_pkg::DATA_W-1:0]  val_r;
  logic [pls_pkg::CNT_W-1:0]   count_r;
  logic [pls_pkg::CNT_W-1:0]   count_nxt;
  logic [pls_pkg::ADDR_W-1:0]  idx_r;
  logic [pls_pkg::ADDR_W-1:0]  idx_nxt;
  logic [pls_pkg::STAT_W-1:0]  stat_r;
  logic [pls_pkg::STAT_W-1:0]  stat_nxt;

  logic                        out_valid_r;
  logic [pls_pkg::DATA_W-1:0]  read_value_r;
  logic [pls_pkg::STAT_W-1:0]  status_r;
  logic [pls_pkg::COUNT_W-1:0] count_out_r;

  logic [pls_pkg::CMP_W-1:0]   pos_x;
  logic [pls_pkg::CMP_W-1:0]   cnt_x;
  logic [pls_pkg::CMP_W-1:0]   idx_x;
  logic                        is_insert;
  logic                        more;
  logic [pls_pkg::ADDR_W-1:0]  rd_addr;
  logic [pls_pkg::ADDR_W-1:0]  wr_addr;
  logic [pls_pkg::DATA_W-1:0]  wr_data;
  logic                        mem_we;
  logic                        mem_re;

  assign pos_x     = pls_pkg::CMP_W'(pos_r);
  assign cnt_x     = pls_pkg::CMP_W'(count_r);
  assign idx_x     = pls_pkg::CMP_W'(idx_r);
  assign is_insert = (op_r == pls_pkg::FUNC_INSERT);

  always_comb begin
    stat_nxt = pls_pkg::STAT_DONE;
    if (is_insert) begin
      if (pos_x > cnt_x) begin
        stat_nxt = pls_pkg::STAT_RANGE;
      end else if (count_r == pls_pkg::CNT_W'(pls_pkg::CAPACITY)) begin
        stat_nxt = pls_pkg::STAT_FULL;
      end
    end else if (op_r == pls_pkg::FUNC_DELETE || op_r == pls_pkg::FUNC_RETRIEVE) begin
      if (pos_x >= cnt_x) stat_nxt = pls_pkg::STAT_RANGE;
    end
  end

  // insert moves entries down from the tail toward pos, delete moves from pos toward the tail
  assign more = is_insert ? (idx_x > pos_x) : ((idx_x + pls_pkg::CMP_W'(1)) < cnt_x);

  assign sts.op       = op_r;
  assign sts.ok       = (stat_nxt == pls_pkg::STAT_DONE);
  assign sts.more     = more;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    if (cmd.rd_fetch) begin
      rd_addr = pls_pkg::ADDR_W'(pos_r);
    end else if (is_insert) begin
      rd_addr = idx_r - pls_pkg::ADDR_W'(1);
    end else begin
      rd_addr = idx_r + pls_pkg::ADDR_W'(1);
    end
  end

  assign mem_re  = cmd.rd_fetch || cmd.rd_move;
  assign mem_we  = cmd.put || cmd.wr_move;
  assign wr_addr = cmd.put ? pls_pkg::ADDR_W'(pos_r) : idx_r;
  assign wr_data = cmd.put ? val_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) store_r[wr_addr] <= wr_data;
    if (mem_re) rd_data_r <= store_r[rd_addr];
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.check) begin
      idx_nxt = is_insert ? pls_pkg::ADDR_W'(count_r) : pls_pkg::ADDR_W'(pos_r);
    end else if (cmd.wr_move) begin
      idx_nxt = is_insert ? (idx_r - pls_pkg::ADDR_W'(1)) : (idx_r + pls_pkg::ADDR_W'(1));
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + pls_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - pls_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_func;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.check) stat_r <= stat_nxt;
    idx_r <= idx_nxt;
    if (cmd.load_out) begin
      read_value_r <= (op_r == pls_pkg::FUNC_RETRIEVE && stat_r == pls_pkg::STAT_DONE) ?
                      rd_data_r : '0;
      status_r     <= stat_r;
      count_out_r  <= pls_pkg::COUNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = read_value_r;
  assign out_status     = status_r;
  assign out_count      = count_out_r;

  `PLS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= pls_pkg::CNT_W'(pls_pkg::CAPACITY), "count above capacity")
  `PLS_ASSERT_SAME(a_put_not_full, cmd.put, count_r < pls_pkg::CNT_W'(pls_pkg::CAPACITY), "insert into full store")
  `PLS_ASSERT_NEXT(a_move_pair, cmd.rd_move, cmd.wr_move, "shift read not followed by write")
  `PLS_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready, "pending result overwritten")

endmodule

### hdl/positional_list_store_unit.sv
// Ordered list of signed 32-bit entries in a 64-entry single-port-style store, with an entry
// count. in_tuser selects insert, delete or retrieve; every transaction yields one result
// carrying the read value, a status (done, out of range, full) and the count afterwards.
// One request is worked at a time. Retrieve, out-of-range, full and unused selectors go
// from the check step straight to the result step, with no shifting of entries.
// Insert and delete shift the entries between the position and the tail one at a time
// through the store's registered read port, each moved entry taking a read step and then
// a write step. A stalled result holds the block in its last step. A new request is
// accepted as soon as the previous one has reached the result register.
module positional_list_store_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pls_pkg::IN_DATA_W-1:0]  in_tdata,   // position[6:0], value[38:7], pad
  input  logic [pls_pkg::FUNC_W-1:0]     in_tuser,   // func[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pls_pkg::OUT_DATA_W-1:0] out_tdata   // read_value[31:0], status[33:32],
                                                     // count[40:34], pad
);

  pls_pkg::cmd_t               cmd;
  pls_pkg::sts_t               sts;
  logic [pls_pkg::DATA_W-1:0]  read_value;
  logic [pls_pkg::STAT_W-1:0]  status;
  logic [pls_pkg::COUNT_W-1:0] count;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pls_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_tuser),
    .in_position    (in_tdata[pls_pkg::POS_W-1:0]),
    .in_value       (in_tdata[pls_pkg::POS_W +: pls_pkg::DATA_W]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_read_value (read_value),
    .out_status     (status),
    .out_count      (count)
  );

  assign out_tdata = pls_pkg::OUT_DATA_W'({count, status, read_value});

endmodule
